FILE: hw/rtl/spit_pkg.sv
// ----------------------------------------------------------------------------
// spit_pkg: shared types for the shape pair intersection test
// Coordinate width, pair-kind codes, channel payloads and the queued job.
// ----------------------------------------------------------------------------
package spit_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [3:0] {
    OP_PT_RECT   = 4'd0,
    OP_PT_CIRC   = 4'd1,
    OP_PT_LINE   = 4'd2,
    OP_RECT_RECT = 4'd3,
    OP_RECT_CIRC = 4'd4,
    OP_CIRC_CIRC = 4'd5,
    OP_SEG_SEG   = 4'd6,
    OP_SEG_RECT  = 4'd7,
    OP_SEG_CIRC  = 4'd8
  } op_t;

  typedef struct packed {
    logic [3:0] op;
    coord_t     a_x;
    coord_t     a_y;
    coord_t     a_u;
    coord_t     a_v;
    coord_t     b_x;
    coord_t     b_y;
    coord_t     b_u;
    coord_t     b_v;
  } req_t;

  typedef struct packed {
    logic hit;
    logic bad_op;
  } rsp_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    logic       bad_op;
    logic [3:0] op;
    coord_t     a_x;
    coord_t     a_y;
    coord_t     a_u;
    coord_t     a_v;
    coord_t     b_x;
    coord_t     b_y;
    coord_t     b_u;
    coord_t     b_v;
  } job_t;

endpackage

FILE: hw/rtl/shape_pair_intersection_test.sv
// ----------------------------------------------------------------------------
// shape_pair_intersection_test: 2D shape pair overlap test
// Exact integer overlap tests for nine point, rect, circle and segment pairs.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload          | handshake
//   --------+-----------+------------------+----------------------------
//   req     | in        | spit_pkg::req_t  | req_valid / req_stall
//   rsp     | out       | spit_pkg::rsp_t  | rsp_valid / rsp_stall
//
// One pair per cycle sustained while rsp is not stalled. A request is
// registered in the front end, waits in a four-entry job queue, then passes
// a five-stage back end whose last stage is the output register. The segment
// units and the segment-circle interior products set the back end depth.
// Reset (synchronous, active high) empties the queue and clears all valids.
// A stall on rsp freezes the back end; the queue absorbs requests until full,
// then req_stall rises.
//
module shape_pair_intersection_test (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  spit_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output spit_pkg::rsp_t rsp
);

  logic           f_valid;
  spit_pkg::job_t f_job;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;
  spit_pkg::job_t q_head;

  // Front end: register the request and classify the op.
  spit_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .job_valid (f_valid),
    .job       (f_job),
    .job_full  (q_full)
  );

  // Queue: decouple intake from the pipeline so each side stalls on its own.
  spit_queue #(
    .DEPTH (spit_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back end: evaluate the pair and hold the result until its transfer.
  spit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_not_empty),
    .job       (q_head),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: hw/rtl/spit_front.sv
// ----------------------------------------------------------------------------
// spit_front: request intake
// Register each request, flag undefined pair kinds, push into the job queue.
// ----------------------------------------------------------------------------
module spit_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spit_pkg::req_t req,
  output logic          job_valid,
  output spit_pkg::job_t job,
  input  logic          job_full
);

  logic accept;

  // Hold the request in place while the queue is full.
  assign req_stall = job_valid && job_full;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!job_valid || !job_full) begin
      job_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.bad_op <= (req.op > spit_pkg::OP_SEG_CIRC);
      job.op     <= req.op;
      job.a_x    <= req.a_x;
      job.a_y    <= req.a_y;
      job.a_u    <= req.a_u;
      job.a_v    <= req.a_v;
      job.b_x    <= req.b_x;
      job.b_y    <= req.b_y;
      job.b_u    <= req.b_u;
      job.b_v    <= req.b_v;
    end
  end

endmodule

FILE: hw/rtl/spit_queue.sv
// ----------------------------------------------------------------------------
// spit_queue: job queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module spit_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  spit_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output spit_pkg::job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  spit_pkg::job_t store [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/spit_seg_unit.sv
// ----------------------------------------------------------------------------
// spit_seg_unit: segment crossing test
// Four-stage pipeline: deltas, cross products, numerators, range check.
// ----------------------------------------------------------------------------
module spit_seg_unit (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [spit_pkg::COORD_WIDTH:0] a1x,
  input  logic signed [spit_pkg::COORD_WIDTH:0] a1y,
  input  logic signed [spit_pkg::COORD_WIDTH:0] a2x,
  input  logic signed [spit_pkg::COORD_WIDTH:0] a2y,
  input  logic signed [spit_pkg::COORD_WIDTH:0] b1x,
  input  logic signed [spit_pkg::COORD_WIDTH:0] b1y,
  input  logic signed [spit_pkg::COORD_WIDTH:0] b2x,
  input  logic signed [spit_pkg::COORD_WIDTH:0] b2y,
  output logic                                hit
);

  localparam int CW = spit_pkg::COORD_WIDTH + 1;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  logic signed [DW-1:0] ex, ey, dx, dy, cx, cy;
  logic signed [PW-1:0] p_exdy, p_eydx, p_cxdy, p_cydx, p_cxey, p_cyex;
  logic signed [NW-1:0] den, tn, un;
  logic                 den_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      ex <= DW'(a2x) - DW'(a1x);
      ey <= DW'(a2y) - DW'(a1y);
      dx <= DW'(b2x) - DW'(b1x);
      dy <= DW'(b2y) - DW'(b1y);
      cx <= DW'(b1x) - DW'(a1x);
      cy <= DW'(b1y) - DW'(a1y);

      p_exdy <= ex * dy;
      p_eydx <= ey * dx;
      p_cxdy <= cx * dy;
      p_cydx <= cy * dx;
      p_cxey <= cx * ey;
      p_cyex <= cy * ex;

      den <= NW'(p_exdy) - NW'(p_eydx);
      tn  <= NW'(p_cxdy) - NW'(p_cydx);
      un  <= NW'(p_cxey) - NW'(p_cyex);

      // Parallel segments never hit; a negative denominator flips the range.
      if (den == '0) begin
        hit <= 1'b0;
      end else if (den_pos) begin
        hit <= (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
      end else begin
        hit <= (tn <= 0) && (tn >= den) && (un <= 0) && (un >= den);
      end
    end
  end

  assign den_pos = !den[NW-1];

endmodule

FILE: hw/rtl/spit_back.sv
// ----------------------------------------------------------------------------
// spit_back: intersection pipeline
// Five stages that evaluate every pair kind and pick the one the op asks for.
// ----------------------------------------------------------------------------
module spit_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  spit_pkg::job_t job,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output spit_pkg::rsp_t rsp
);

  localparam int W  = spit_pkg::COORD_WIDTH;
  localparam int DW = W + 4;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int EW = W + 1;
  localparam int QW = 2 * EW;
  localparam int LW = QW + 1;
  localparam int MW = 2 * LW;
  localparam int XW = MW + 1;

  logic en;
  logic v1, v2, v3, v4;

  // Whole pipeline advances together; the last stage is the output register.
  assign en  = !rsp_valid || !rsp_stall;
  assign pop = en && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; rsp_valid <= 1'b0;
    end else if (en) begin
      v1 <= job_valid; v2 <= v1; v3 <= v2; v4 <= v3; rsp_valid <= v4;
    end
  end

  // Stage 0 operands.
  logic signed [DW-1:0] ax, ay, au, av, bx, by, bu, bv;
  logic signed [DW-1:0] tx, ty, ddx, ddy, r2;
  logic signed [EW-1:0] sax, say, sau, sav, sbx, sby, sbu, sbv, fx, fy;
  logic signed [EW-1:0] u0x, u0y;
  logic                 hit0, hit3, far4, near4;
  logic                 seg_hit0, seg_hit1, seg_hit2, seg_hit3;

  assign ax = DW'(job.a_x);
  assign ay = DW'(job.a_y);
  assign au = DW'(job.a_u);
  assign av = DW'(job.a_v);
  assign bx = DW'(job.b_x);
  assign by = DW'(job.b_y);
  assign bu = DW'(job.b_u);
  assign bv = DW'(job.b_v);

  assign hit0 = (ax >= bx) && (ay >= by) && (ax <= bx + bu) && (ay <= by + bv);
  assign hit3 = (ax < bx + bu) && (ax + au > bx) && (ay < by + bv) && (ay + av > by);

  // Rect-circle works on doubled values so the rect centre stays integral.
  assign tx    = (bx <<< 1) - (ax <<< 1) - au;
  assign ty    = (by <<< 1) - (ay <<< 1) - av;
  assign ddx   = tx[DW-1] ? -tx : tx;
  assign ddy   = ty[DW-1] ? -ty : ty;
  assign r2    = bu <<< 1;
  assign far4  = (ddx > au + r2) || (ddy > av + r2);
  assign near4 = (ddx <= au) || (ddy <= av);

  assign sax = EW'(job.a_x);
  assign say = EW'(job.a_y);
  assign sau = EW'(job.a_u);
  assign sav = EW'(job.a_v);
  assign sbx = EW'(job.b_x);
  assign sby = EW'(job.b_y);
  assign sbu = EW'(job.b_u);
  assign sbv = EW'(job.b_v);
  assign fx  = sbx + sbu;
  assign fy  = sby + sbv;
  assign u0x = (job.op == spit_pkg::OP_SEG_SEG) ? sbu : fx;
  assign u0y = (job.op == spit_pkg::OP_SEG_SEG) ? sbv : sby;

  spit_seg_unit u_seg0 (
    .clk(clk), .en(en),
    .a1x(sax), .a1y(say), .a2x(sau), .a2y(sav),
    .b1x(sbx), .b1y(sby), .b2x(u0x), .b2y(u0y), .hit(seg_hit0)
  );
  spit_seg_unit u_seg1 (
    .clk(clk), .en(en),
    .a1x(sax), .a1y(say), .a2x(sau), .a2y(sav),
    .b1x(sbx), .b1y(sby), .b2x(sbx), .b2y(fy), .hit(seg_hit1)
  );
  spit_seg_unit u_seg2 (
    .clk(clk), .en(en),
    .a1x(sax), .a1y(say), .a2x(sau), .a2y(sav),
    .b1x(fx), .b1y(fy), .b2x(fx), .b2y(sby), .hit(seg_hit2)
  );
  spit_seg_unit u_seg3 (
    .clk(clk), .en(en),
    .a1x(sax), .a1y(say), .a2x(sau), .a2y(sav),
    .b1x(fx), .b1y(fy), .b2x(sbx), .b2y(fy), .hit(seg_hit3)
  );

  // Stage 1: differences.
  logic [3:0]           op1, op2, op3, op4;
  logic                 bad1, bad2, bad3, bad4;
  logic                 h1, h2, h3, h4;
  logic signed [DW-1:0] s1_dx, s1_dy, s1_rad, s1_px, s1_py, s1_qx, s1_qy;
  logic signed [DW-1:0] s1_e4x, s1_e4y, s1_r2;
  logic                 s1_rneg, s1_far, s1_near;
  logic signed [EW-1:0] s1_ex, s1_ey, s1_cx, s1_cy, s1_gx, s1_gy, s1_bu;
  logic signed [DW-1:0] rad;

  assign rad = (job.op == spit_pkg::OP_CIRC_CIRC) ? au + bu : bu;

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= job.op;
      bad1   <= job.bad_op;
      h1     <= (job.op == spit_pkg::OP_PT_RECT)   ? hit0 :
                (job.op == spit_pkg::OP_RECT_RECT) ? hit3 : 1'b0;
      s1_dx  <= ax - bx;
      s1_dy  <= ay - by;
      s1_rad <= rad;
      s1_rneg <= rad[DW-1];
      s1_px  <= bx - bu;
      s1_py  <= by - bv;
      s1_qx  <= ax - bu;
      s1_qy  <= ay - bv;
      s1_e4x <= ddx - au;
      s1_e4y <= ddy - av;
      s1_r2  <= r2;
      s1_far <= far4;
      s1_near <= near4;
      s1_ex  <= sau - sax;
      s1_ey  <= sav - say;
      s1_cx  <= sbx - sax;
      s1_cy  <= sby - say;
      s1_gx  <= sbx - sau;
      s1_gy  <= sby - sav;
      s1_bu  <= sbu;
    end
  end

  // Stage 2: squares and cross products.
  logic signed [PW-1:0] s2_dx2, s2_dy2, s2_rad2, s2_pq, s2_qp, s2_e4x2, s2_e4y2, s2_r22;
  logic                 s2_rneg, s2_far, s2_near;
  logic signed [QW-1:0] s2_ex2, s2_ey2, s2_cex, s2_cey, s2_rr, s2_cx2, s2_cy2;
  logic signed [QW-1:0] s2_gx2, s2_gy2;

  always_ff @(posedge clk) begin
    if (en) begin
      op2     <= op1;
      bad2    <= bad1;
      h2      <= h1;
      s2_dx2  <= s1_dx * s1_dx;
      s2_dy2  <= s1_dy * s1_dy;
      s2_rad2 <= s1_rad * s1_rad;
      s2_rneg <= s1_rneg;
      s2_pq   <= s1_px * s1_qy;
      s2_qp   <= s1_py * s1_qx;
      s2_e4x2 <= s1_e4x * s1_e4x;
      s2_e4y2 <= s1_e4y * s1_e4y;
      s2_r22  <= s1_r2 * s1_r2;
      s2_far  <= s1_far;
      s2_near <= s1_near;
      s2_ex2  <= s1_ex * s1_ex;
      s2_ey2  <= s1_ey * s1_ey;
      s2_cex  <= s1_cx * s1_ex;
      s2_cey  <= s1_cy * s1_ey;
      s2_rr   <= s1_bu * s1_bu;
      s2_cx2  <= s1_cx * s1_cx;
      s2_cy2  <= s1_cy * s1_cy;
      s2_gx2  <= s1_gx * s1_gx;
      s2_gy2  <= s1_gy * s1_gy;
    end
  end

  // Stage 3: distance sums and the closed-form kinds.
  logic signed [SW-1:0] d2, e2;
  logic                 hit1, hit2, hit4, hit5;
  logic signed [LW-1:0] len, dotn, rrw, ac2, bd2;
  logic                 len_zero, n_nonpos, early, early_hit;
  logic                 h3_next;
  logic signed [LW-1:0] s3_len, s3_n, s3_rr, s3_ac2;
  logic                 s3_early, s3_early_hit;

  assign d2   = SW'(s2_dx2) + SW'(s2_dy2);
  assign e2   = SW'(s2_e4x2) + SW'(s2_e4y2);
  assign hit1 = d2 <= SW'(s2_rad2);
  assign hit5 = !s2_rneg && hit1;
  assign hit2 = (s2_pq == s2_qp);
  assign hit4 = !s2_far && (s2_near || (e2 <= SW'(s2_r22)));

  assign len       = LW'(s2_ex2) + LW'(s2_ey2);
  assign dotn      = LW'(s2_cex) + LW'(s2_cey);
  assign rrw       = LW'(s2_rr);
  assign ac2       = LW'(s2_cx2) + LW'(s2_cy2);
  assign bd2       = LW'(s2_gx2) + LW'(s2_gy2);
  assign len_zero  = (len == '0);
  assign n_nonpos  = (dotn <= 0);
  // Closest point is an end: the start, the end, or else the interior.
  assign early     = len_zero || n_nonpos || (len <= dotn);
  assign early_hit = (len_zero || n_nonpos) ? (ac2 <= rrw) : (bd2 <= rrw);

  always_comb begin
    unique case (op2)
      spit_pkg::OP_PT_CIRC:   h3_next = hit1;
      spit_pkg::OP_PT_LINE:   h3_next = hit2;
      spit_pkg::OP_RECT_CIRC: h3_next = hit4;
      spit_pkg::OP_CIRC_CIRC: h3_next = hit5;
      default:                h3_next = h2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3          <= op2;
      bad3         <= bad2;
      h3           <= h3_next;
      s3_len       <= len;
      s3_n         <= dotn;
      s3_rr        <= rrw;
      s3_ac2       <= ac2;
      s3_early     <= early;
      s3_early_hit <= early_hit;
    end
  end

  // Stage 4: interior case products for segment-circle.
  logic signed [MW-1:0] s4_al, s4_nn, s4_rl;
  logic                 s4_early, s4_early_hit;

  always_ff @(posedge clk) begin
    if (en) begin
      op4          <= op3;
      bad4         <= bad3;
      h4           <= h3;
      s4_al        <= s3_ac2 * s3_len;
      s4_nn        <= s3_n * s3_n;
      s4_rl        <= s3_rr * s3_len;
      s4_early     <= s3_early;
      s4_early_hit <= s3_early_hit;
    end
  end

  // Stage 5: final select into the output register.
  logic signed [XW-1:0] lhs;
  logic                 hit8, hit_final;

  assign lhs  = XW'(s4_al) - XW'(s4_nn);
  assign hit8 = s4_early ? s4_early_hit : (lhs <= XW'(s4_rl));

  always_comb begin
    unique case (op4)
      spit_pkg::OP_SEG_SEG:  hit_final = seg_hit0;
      spit_pkg::OP_SEG_RECT: hit_final = seg_hit0 || seg_hit1 || seg_hit2 || seg_hit3;
      spit_pkg::OP_SEG_CIRC: hit_final = hit8;
      default:               hit_final = h4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.hit    <= hit_final && !bad4;
      rsp.bad_op <= bad4;
    end
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: shape pair intersection test
// Drives shape pairs over req, predicts hit and bad_op with exact wide
// integer arithmetic, and checks each rsp transfer in order. Directed cases
// cover edges and every pair kind; random pairs follow with random idling
// on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [127:0] wide_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  spit_pkg::req_t req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  spit_pkg::rsp_t rsp;

  spit_pkg::rsp_t expected_rsps[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     idle_enable = 1'b0;   // random idling on both sides
  int     hold_cycles = 0;      // long receiver hold-off still pending

  localparam int CYCLE_LIMIT = 400000;

  shape_pair_intersection_test DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Squared length of a vector.
  function automatic wide_t sq_len(wide_t dx, wide_t dy);
    return dx * dx + dy * dy;
  endfunction

  // Do segment a1-a2 and b1-b2 cross? Parallel, collinear included, gives 0.
  function automatic bit segs_cross(wide_t ax1, wide_t ay1, wide_t ax2, wide_t ay2,
                                    wide_t bx1, wide_t by1, wide_t bx2, wide_t by2);
    wide_t ex, ey, dx, dy, cx, cy, den, tn, un;
    ex = ax2 - ax1; ey = ay2 - ay1;
    dx = bx2 - bx1; dy = by2 - by1;
    cx = bx1 - ax1; cy = by1 - ay1;
    den = ex * dy - ey * dx;
    tn  = cx * dy - cy * dx;
    un  = cx * ey - cy * ex;
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    return tn >= 0 && tn <= den && un >= 0 && un <= den;
  endfunction

  // Overlap verdict for one shape pair.
  function automatic spit_pkg::rsp_t pair_overlap(spit_pkg::req_t r);
    spit_pkg::rsp_t res;
    wide_t ax, ay, au, av, bx, by, bu, bv;
    wide_t px, py, qx, qy, ddx, ddy, r2, s, fx, fy;
    wide_t ex, ey, cx, cy, len, n, rr, ac2;
    ax = r.a_x; ay = r.a_y; au = r.a_u; av = r.a_v;
    bx = r.b_x; by = r.b_y; bu = r.b_u; bv = r.b_v;
    res = '0;
    case (r.op)
      spit_pkg::OP_PT_RECT:
        res.hit = ax >= bx && ay >= by && ax <= bx + bu && ay <= by + bv;
      spit_pkg::OP_PT_CIRC:
        res.hit = sq_len(ax - bx, ay - by) <= bu * bu;
      spit_pkg::OP_PT_LINE: begin
        px = bx - bu; py = by - bv; qx = ax - bu; qy = ay - bv;
        res.hit = (px * qy - py * qx) == 0;
      end
      spit_pkg::OP_RECT_RECT:
        res.hit = ax < bx + bu && ax + au > bx && ay < by + bv && ay + av > by;
      spit_pkg::OP_RECT_CIRC: begin
        // work in doubled units so the rect centre stays integral
        ddx = 2 * bx - 2 * ax - au;
        ddy = 2 * by - 2 * ay - av;
        r2 = 2 * bu;
        if (ddx < 0) ddx = -ddx;
        if (ddy < 0) ddy = -ddy;
        if (ddx > au + r2 || ddy > av + r2) res.hit = 1'b0;
        else if (ddx <= au || ddy <= av) res.hit = 1'b1;
        else res.hit = sq_len(ddx - au, ddy - av) <= r2 * r2;
      end
      spit_pkg::OP_CIRC_CIRC: begin
        s = au + bu;
        res.hit = s >= 0 && sq_len(bx - ax, by - ay) <= s * s;
      end
      spit_pkg::OP_SEG_SEG:
        res.hit = segs_cross(ax, ay, au, av, bx, by, bu, bv);
      spit_pkg::OP_SEG_RECT: begin
        fx = bx + bu; fy = by + bv;
        res.hit = segs_cross(ax, ay, au, av, bx, by, fx, by)
               || segs_cross(ax, ay, au, av, bx, by, bx, fy)
               || segs_cross(ax, ay, au, av, fx, fy, fx, by)
               || segs_cross(ax, ay, au, av, fx, fy, bx, fy);
      end
      spit_pkg::OP_SEG_CIRC: begin
        ex = au - ax; ey = av - ay; cx = bx - ax; cy = by - ay;
        len = sq_len(ex, ey);
        n = cx * ex + cy * ey;
        rr = bu * bu;
        ac2 = sq_len(cx, cy);
        if (len == 0 || n <= 0) res.hit = ac2 <= rr;
        else if (len <= n) res.hit = sq_len(bx - au, by - av) <= rr;
        else res.hit = ac2 * len - n * n <= rr * len;
      end
      default:
        res.bad_op = 1'b1;
    endcase
    return res;
  endfunction

  task automatic report(string what, spit_pkg::rsp_t got, spit_pkg::rsp_t want);
    mismatches++;
    $display("error at cycle %0d: %s got hit=%b bad_op=%b want hit=%b bad_op=%b",
             cycles, what, got.hit, got.bad_op, want.hit, want.bad_op);
  endtask

  // Offer one pair, with an optional random gap, and hold until transfer.
  // Valid stays high after the transfer so pairs can follow back to back;
  // it drops only while idling.
  task automatic send_pair(spit_pkg::req_t r);
    while (idle_enable && $urandom_range(99) < 33) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsps.push_back(pair_overlap(r));
  endtask

  // Send one pair as part of a stream.
  task automatic send_stream(spit_pkg::req_t r);
    send_pair(r);
  endtask

  function automatic spit_pkg::coord_t rnd_coord();
    case ($urandom_range(5))
      0: return spit_pkg::coord_t'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return spit_pkg::coord_t'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  function automatic spit_pkg::req_t rnd_pair(bit any_op);
    spit_pkg::req_t r;
    r.op  = any_op ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    r.a_x = rnd_coord(); r.a_y = rnd_coord();
    r.a_u = rnd_coord(); r.a_v = rnd_coord();
    r.b_x = rnd_coord(); r.b_y = rnd_coord();
    r.b_u = rnd_coord(); r.b_v = rnd_coord();
    return r;
  endfunction

  function automatic spit_pkg::req_t mk(logic [3:0] op, int ax, int ay, int au, int av,
                                        int bx, int by, int bu, int bv);
    spit_pkg::req_t r;
    r.op = op;
    r.a_x = spit_pkg::coord_t'(ax); r.a_y = spit_pkg::coord_t'(ay);
    r.a_u = spit_pkg::coord_t'(au); r.a_v = spit_pkg::coord_t'(av);
    r.b_x = spit_pkg::coord_t'(bx); r.b_y = spit_pkg::coord_t'(by);
    r.b_u = spit_pkg::coord_t'(bu); r.b_v = spit_pkg::coord_t'(bv);
    return r;
  endfunction

  // Directed: edges of each pair kind, the special cases, bad op codes.
  task automatic test_directed();
    send_stream(mk(spit_pkg::OP_PT_RECT, 10, 10, 0, 0, 0, 0, 10, 10));   // closed corner
    send_stream(mk(spit_pkg::OP_PT_RECT, 11, 5, 0, 0, 0, 0, 10, 10));
    send_stream(mk(spit_pkg::OP_PT_CIRC, 3, 4, 0, 0, 0, 0, 5, 0));       // on the rim
    send_stream(mk(spit_pkg::OP_PT_CIRC, -32768, -32768, 0, 0, 32767, 32767, -32768, 0));
    send_stream(mk(spit_pkg::OP_PT_LINE, 2, 2, 0, 0, 5, 5, -3, -3));     // exact zero cross
    send_stream(mk(spit_pkg::OP_PT_LINE, 2, 3, 0, 0, 5, 5, -3, -3));
    send_stream(mk(spit_pkg::OP_RECT_RECT, 0, 0, 10, 10, 10, 0, 5, 5));  // touching: open
    send_stream(mk(spit_pkg::OP_RECT_RECT, 0, 0, 10, 10, 9, 9, 5, 5));
    send_stream(mk(spit_pkg::OP_RECT_CIRC, 0, 0, 10, 10, 13, 14, 5, 0)); // corner region
    send_stream(mk(spit_pkg::OP_RECT_CIRC, 0, 0, 10, 10, 14, 14, 5, 0));
    send_stream(mk(spit_pkg::OP_RECT_CIRC, 0, 0, -10, 7, 3, 3, -2, 0));  // negative sizes
    send_stream(mk(spit_pkg::OP_CIRC_CIRC, 0, 0, 3, 0, 8, 0, 5, 0));
    send_stream(mk(spit_pkg::OP_CIRC_CIRC, 0, 0, -6, 0, 0, 0, 5, 0));    // negative radius sum
    send_stream(mk(spit_pkg::OP_SEG_SEG, 0, 0, 10, 10, 0, 10, 10, 0));
    send_stream(mk(spit_pkg::OP_SEG_SEG, 0, 0, 10, 0, 5, 0, 20, 0));     // collinear: no hit
    send_stream(mk(spit_pkg::OP_SEG_SEG, -32768, -32768, 32767, 32767,
                   -32768, 32767, 32767, -32768));
    send_stream(mk(spit_pkg::OP_SEG_RECT, 2, 2, 3, 3, 0, 0, 10, 10));    // wholly inside
    send_stream(mk(spit_pkg::OP_SEG_RECT, -5, 5, 5, 5, 0, 0, 10, 10));
    send_stream(mk(spit_pkg::OP_SEG_CIRC, 3, 4, 3, 4, 0, 0, 5, 0));      // zero length
    send_stream(mk(spit_pkg::OP_SEG_CIRC, -10, 3, 10, 3, 0, 0, 3, 0));   // tangent interior
    send_stream(mk(spit_pkg::OP_SEG_CIRC, -10, 4, 10, 4, 0, 0, 3, 0));
    send_stream(mk(spit_pkg::OP_SEG_CIRC, 32767, 32767, -32768, -32768,
                   32767, -32768, 32767, 0));
    send_stream(mk(4'd9, 1, 2, 3, 4, 5, 6, 7, 8));
    send_stream(mk(4'd15, -1, -1, -1, -1, -1, -1, -1, -1));
  endtask

  // Random pairs with idling on; a stretch with no idling in the middle.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      idle_enable = !(i >= count / 3 && i < count / 2);
      send_stream(rnd_pair($urandom_range(9) == 0));
    end
    idle_enable = 1'b1;
  endtask

  // Hold rsp off for a long stretch while pairs keep coming, to fill the queue.
  task automatic test_backpressure();
    hold_cycles = 60;
    idle_enable = 1'b0;
    for (int i = 0; i < 30; i++) send_stream(rnd_pair(1'b0));
    idle_enable = 1'b1;
  endtask

  // Receiver: random stall, or a long hold-off when one is pending.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_cycles > 0) begin
      rsp_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp_stall <= idle_enable && !rst && ($urandom_range(99) < 33);
    end
  end

  // Check every rsp transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        report("unexpected result", rsp, '0);
      end else begin
        if (rsp !== expected_rsps[0]) report("field mismatch", rsp, expected_rsps[0]);
        void'(expected_rsps.pop_front());
      end
    end
  end

  // Timeout.
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("shape_pair_intersection_test: mismatch");
      $finish;
    end
  end

  initial begin
    int drain;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_random(560);
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    // allow stray results to show up after the last expected one
    drain = 0;
    while (drain < 20) begin
      @(posedge clk);
      drain++;
    end
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("shape_pair_intersection_test: match");
    end else begin
      $display("shape_pair_intersection_test: mismatch");
    end
    $finish;
  end

endmodule
